// File: rtl/pfbc_pkg.sv
`timescale 1ns / 1ps

package pfbc_pkg;

  // Default palette depth, also the largest supported.
  localparam int unsigned PALETTE_DEPTH_DEF = 256;

  // Configuration port geometry.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 9;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_FORMAT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEST_FORMAT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLEND_FLAGS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PALETTE_COLORS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SWAP_BYTES     = 3'd4;

  // Commands carried in the input tuser.
  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_CONVERT = 1'b1;

  // Source formats.
  localparam logic SRC_FMT_INDEX = 1'b0;
  localparam logic SRC_FMT_ARGB  = 1'b1;

  // Destination formats; the fourth code is unsupported.
  localparam logic [1:0] DST_FMT_8  = 2'd0;
  localparam logic [1:0] DST_FMT_16 = 2'd1;
  localparam logic [1:0] DST_FMT_32 = 2'd2;

  // Reset values of the configuration registers.
  localparam logic       SOURCE_FORMAT_RST  = SRC_FMT_INDEX;
  localparam logic [1:0] DEST_FORMAT_RST    = DST_FMT_32;
  localparam logic [1:0] BLEND_FLAGS_RST    = 2'd0;
  localparam logic [8:0] PALETTE_COLORS_RST = 9'd0;
  localparam logic       SWAP_BYTES_RST     = 1'b1;

  localparam logic [31:0] ALPHA_MASK = 32'hFF00_0000;

  function automatic logic [15:0] swap16(input logic [15:0] v);
    return {v[7:0], v[15:8]};
  endfunction

  // Packs the low three bytes of an ARGB word to RGB565.
  function automatic logic [15:0] pack565(input logic [31:0] c, input logic swap);
    logic [15:0] v;
    v = {c[7:3], c[15:10], c[23:19]};
    return swap ? swap16(v) : v;
  endfunction

  // (s - d) * a / 255 + d, truncated toward zero. The division works on the
  // magnitude; (m + 1 + (m >> 8)) >> 8 is exact for every 8 by 8-bit product.
  function automatic logic [7:0] blend_ch(input logic [7:0] s, input logic [7:0] d,
                                          input logic [7:0] a);
    logic [7:0]  mag;
    logic [15:0] m;
    logic [16:0] t;
    logic [7:0]  q;
    mag = (s >= d) ? (s - d) : (d - s);
    m   = mag * a;
    t   = {1'b0, m} + 17'd1 + {9'd0, m[15:8]};
    q   = t[15:8];
    return (s >= d) ? (d + q) : (d - q);
  endfunction

endpackage

// File: rtl/pixel_format_blit_converter.sv
`timescale 1ns / 1ps

// Per-pixel blit converter. Each input transfer is either a palette load
// (tuser = 0), which writes one ARGB word to the palette memory and gives no
// result, or a pixel conversion (tuser = 1), which gives exactly one result:
// the new destination pixel, a write strobe and an unsupported flag. One
// transfer is taken every clock while stage 1 is empty or can advance. The
// accepting edge captures the operands and the synchronous palette read; the
// output register loads the format conversion and blend once it can advance.
// The user must write configuration through the cfg port only while no
// conversion is in flight; the block itself does not enforce this.
module pixel_format_blit_converter #(
  parameter int unsigned PALETTE_DEPTH = pfbc_pkg::PALETTE_DEPTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration write port.
  input  logic                           cfg_we_i,
  input  logic [pfbc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [pfbc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // Input stream.
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // [31:0] source_pixel, [39:32] palette_slot, [71:40] dest_pixel
  input  logic [71:0]                    s_axis_tdata_i,
  // [0] command
  input  logic [0:0]                     s_axis_tuser_i,
  // Output stream.
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // [31:0] pixel_out
  output logic [31:0]                    m_axis_tdata_o,
  // [0] write_enable, [1] unsupported
  output logic [1:0]                     m_axis_tuser_o
);
  import pfbc_pkg::*;

  localparam int unsigned IDX_W = $clog2(PALETTE_DEPTH);
  localparam logic [8:0]  DEPTH_LIM = 9'(PALETTE_DEPTH);

  // Configuration registers.
  logic       source_format_q;
  logic [1:0] dest_format_q;
  logic [1:0] blend_flags_q;
  logic [8:0] palette_colors_q;
  logic       swap_bytes_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      source_format_q  <= SOURCE_FORMAT_RST;
      dest_format_q    <= DEST_FORMAT_RST;
      blend_flags_q    <= BLEND_FLAGS_RST;
      palette_colors_q <= PALETTE_COLORS_RST;
      swap_bytes_q     <= SWAP_BYTES_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SOURCE_FORMAT:  source_format_q  <= cfg_data_i[0];
        CFG_DEST_FORMAT:    dest_format_q    <= cfg_data_i[1:0];
        CFG_BLEND_FLAGS:    blend_flags_q    <= cfg_data_i[1:0];
        CFG_PALETTE_COLORS: palette_colors_q <= cfg_data_i[8:0];
        CFG_SWAP_BYTES:     swap_bytes_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Input fields.
  logic [31:0] in_src;
  logic [7:0]  in_slot;
  logic [31:0] in_dst;
  logic        in_cmd;

  assign in_src  = s_axis_tdata_i[31:0];
  assign in_slot = s_axis_tdata_i[39:32];
  assign in_dst  = s_axis_tdata_i[71:40];
  assign in_cmd  = s_axis_tuser_i[0];

  // Handshake and pipeline advance.
  logic s_accept;
  logic advance;
  logic s1_valid_q;
  logic out_valid_q;

  assign advance         = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = !s1_valid_q || advance;
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;

  // Palette memory: one write port for loads, one registered read port.
  logic [31:0] palette_mem [PALETTE_DEPTH];
  logic [31:0] pal_rd_q;

  always_ff @(posedge clk_i) begin
    if (s_accept && (in_cmd == CMD_LOAD) && ({1'b0, in_slot} < DEPTH_LIM)) begin
      palette_mem[in_slot[IDX_W-1:0]] <= in_src;
    end
    if (s_accept && (in_cmd == CMD_CONVERT)) begin
      pal_rd_q <= palette_mem[in_src[IDX_W-1:0]];
    end
  end

  // Stage 1: conversion operands.
  logic [31:0] s1_src_q;
  logic [31:0] s1_dst_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      s1_valid_q <= s_accept && (in_cmd == CMD_CONVERT);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept && (in_cmd == CMD_CONVERT)) begin
      s1_src_q <= in_src;
      s1_dst_q <= in_dst;
    end
  end

  // Conversion logic.
  logic        test;
  logic        blend;
  logic [7:0]  idx;
  logic        loaded;
  logic [31:0] grey;
  logic [31:0] raw;
  logic [31:0] pal_word;
  logic        clear;
  logic [31:0] dmask;
  logic [15:0] dj;
  logic [7:0]  ch_r;
  logic [7:0]  ch_g;
  logic [7:0]  ch_b;
  logic [15:0] blended;
  logic [31:0] pix_d;
  logic        we_d;
  logic        uns_d;

  assign test     = blend_flags_q[0];
  assign blend    = blend_flags_q[1];
  assign idx      = s1_src_q[7:0];
  assign loaded   = ({1'b0, idx} < palette_colors_q) && ({1'b0, idx} < DEPTH_LIM);
  assign grey     = {8'd0, idx, idx, idx};
  assign raw      = loaded ? pal_rd_q : grey;
  assign pal_word = loaded ? (pal_rd_q ^ ALPHA_MASK) : (grey | ALPHA_MASK);
  assign clear    = (s1_src_q & ALPHA_MASK) == 32'd0;

  // Destination unpacked to 8-bit channels, blended and repacked.
  assign dj      = swap_bytes_q ? swap16(s1_dst_q[15:0]) : s1_dst_q[15:0];
  assign ch_r    = blend_ch(s1_src_q[23:16], {dj[4:0], 3'b000}, s1_src_q[31:24]);
  assign ch_g    = blend_ch(s1_src_q[15:8], {dj[10:5], 2'b00}, s1_src_q[31:24]);
  assign ch_b    = blend_ch(s1_src_q[7:0], {dj[15:11], 3'b000}, s1_src_q[31:24]);
  assign blended = {ch_b[7:3], ch_g[7:2], ch_r[7:3]};

  always_comb begin
    case (dest_format_q)
      DST_FMT_8:  dmask = 32'h0000_00FF;
      DST_FMT_16: dmask = 32'h0000_FFFF;
      default:    dmask = 32'hFFFF_FFFF;
    endcase
  end

  always_comb begin
    pix_d = 32'd0;
    we_d  = 1'b0;
    uns_d = 1'b0;
    if (source_format_q == SRC_FMT_INDEX) begin
      case (dest_format_q)
        DST_FMT_8: begin
          if ((test || blend) && (idx == 8'd0)) begin
            pix_d = s1_dst_q & dmask;
          end else begin
            pix_d = {24'd0, idx};
            we_d  = 1'b1;
          end
        end
        DST_FMT_16: begin
          pix_d = {16'd0, pack565(raw, swap_bytes_q)};
          we_d  = 1'b1;
        end
        DST_FMT_32: begin
          if (test) begin
            if (pal_word[31]) begin
              pix_d = pal_word;
              we_d  = 1'b1;
            end else begin
              pix_d = s1_dst_q & dmask;
            end
          end else if (blend) begin
            uns_d = 1'b1;
          end else begin
            pix_d = pal_word;
            we_d  = 1'b1;
          end
        end
        default: uns_d = 1'b1;
      endcase
    end else begin
      case (dest_format_q)
        DST_FMT_16: begin
          if (blend) begin
            if (clear) begin
              pix_d = s1_dst_q & dmask;
            end else begin
              pix_d = {16'd0, swap_bytes_q ? swap16(blended) : blended};
              we_d  = 1'b1;
            end
          end else if (test && clear) begin
            pix_d = s1_dst_q & dmask;
          end else begin
            pix_d = {16'd0, pack565(s1_src_q, swap_bytes_q)};
            we_d  = 1'b1;
          end
        end
        DST_FMT_32: begin
          if (test) begin
            if (clear) begin
              pix_d = s1_dst_q;
            end else begin
              pix_d = s1_src_q;
              we_d  = 1'b1;
            end
          end else if (blend) begin
            uns_d = 1'b1;
          end else begin
            pix_d = s1_src_q;
            we_d  = 1'b1;
          end
        end
        default: uns_d = 1'b1;
      endcase
    end
  end

  // Output register.
  logic [31:0] out_pix_q;
  logic        out_we_q;
  logic        out_uns_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && s1_valid_q) begin
      out_pix_q <= pix_d;
      out_we_q  <= we_d;
      out_uns_q <= uns_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_pix_q;
  assign m_axis_tuser_o  = {out_uns_q, out_we_q};

  // An unsupported result never carries a write strobe.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o[1]) |-> !m_axis_tuser_o[0])
    else $error("unsupported result with write strobe");

  // An unsupported result carries a zero pixel.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o[1]) |-> (m_axis_tdata_o == 32'd0))
    else $error("unsupported result with nonzero pixel");

  // A palette load never creates a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_accept && (in_cmd == CMD_LOAD)) |=> !s1_valid_q)
    else $error("palette load entered the conversion stage");

  // A conversion held in stage 1 is not lost while the output stalls.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !advance) |=> (s1_valid_q && $stable(s1_src_q)))
    else $error("stage 1 item lost during stall");

  // A conversion accepted with the output register free reaches it next.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && advance) |=> out_valid_q)
    else $error("stage 1 item did not reach the output register");

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import pfbc_pkg::*;

  localparam int unsigned LONG_STALL   = 120;
  localparam int unsigned QUIET_LIMIT  = 2000;
  localparam int unsigned SETTLE_CYCLES = 4;

  typedef struct packed {
    logic        cmd;
    logic [31:0] src;
    logic [7:0]  slot;
    logic [31:0] dst;
  } blit_item_t;

  typedef struct packed {
    logic [31:0] pixel;
    logic        we;
    logic        uns;
  } blit_result_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                  cfg_we   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx  = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic        s_tvalid = 1'b0;
  logic        s_axis_tready_o;
  // [31:0] source_pixel, [39:32] palette_slot, [71:40] dest_pixel
  logic [71:0] s_tdata  = '0;
  // [0] command
  logic [0:0]  s_tuser  = '0;

  logic        m_axis_tvalid_o;
  logic        m_tready = 1'b0;
  // [31:0] pixel_out
  logic [31:0] m_axis_tdata_o;
  // [0] write_enable, [1] unsupported
  logic [1:0]  m_axis_tuser_o;

  pixel_format_blit_converter dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Shadow copy of the configuration and the palette.
  logic        cfg_src    = SOURCE_FORMAT_RST;
  logic [1:0]  cfg_dst    = DEST_FORMAT_RST;
  logic [1:0]  cfg_blend  = BLEND_FLAGS_RST;
  logic [8:0]  cfg_colors = PALETTE_COLORS_RST;
  logic        cfg_swap   = SWAP_BYTES_RST;
  logic [31:0] palette_model [256];
  bit   [255:0] slot_written = '0;

  blit_item_t   blit_queue[$];
  blit_result_t expected_writes[$];
  blit_item_t   cur_item;
  blit_result_t head_write;
  int unsigned  pushed_total   = 0;
  int unsigned  accepted_total = 0;
  int unsigned  mismatches     = 0;
  int unsigned  send_idle_pct  = 0;
  int unsigned  recv_idle_pct  = 0;
  int unsigned  stall_requests = 0;
  int unsigned  stall_served   = 0;
  int unsigned  stall_left     = 0;
  int unsigned  quiet_cycles   = 0;

  function automatic logic [15:0] byte_swap16(logic [15:0] v);
    return {v[7:0], v[15:8]};
  endfunction

  function automatic logic [15:0] to_rgb565(logic [31:0] c);
    logic [15:0] v;
    v = {c[7:3], c[15:10], c[23:19]};
    return cfg_swap ? byte_swap16(v) : v;
  endfunction

  function automatic int mix_channel(int s, int d, int a);
    return ((s - d) * a) / 255 + d;
  endfunction

  function automatic blit_result_t predict_blit(logic [31:0] src, logic [31:0] dst);
    blit_result_t r;
    logic [31:0]  dmask;
    logic [31:0]  raw;
    logic [31:0]  w;
    logic [7:0]   idx;
    logic         loaded;
    logic         do_test;
    logic         do_blend;
    logic         alpha_zero;
    logic [15:0]  j;
    logic [7:0]   r8;
    logic [7:0]   g8;
    logic [7:0]   b8;
    int           a;
    int           dr;
    int           dg;
    int           db;
    r        = '0;
    do_test  = cfg_blend[0];
    do_blend = cfg_blend[1];
    case (cfg_dst)
      DST_FMT_8:  dmask = 32'h0000_00FF;
      DST_FMT_16: dmask = 32'h0000_FFFF;
      default:    dmask = 32'hFFFF_FFFF;
    endcase
    if (cfg_src == SRC_FMT_INDEX) begin
      idx    = src[7:0];
      loaded = ({1'b0, idx} < cfg_colors);
      raw    = loaded ? palette_model[idx] : 32'h0001_0101 * idx;
      if (cfg_dst == DST_FMT_8) begin
        if ((do_test || do_blend) && idx == 8'd0) begin
          r.pixel = dst & dmask;
        end else begin
          r.pixel = {24'd0, idx};
          r.we    = 1'b1;
        end
      end else if (cfg_dst == DST_FMT_32) begin
        // Palette words are stored with inverted alpha; the ramp is opaque.
        w = loaded ? (raw ^ ALPHA_MASK) : (raw | ALPHA_MASK);
        if (do_test) begin
          if (w[31]) begin
            r.pixel = w;
            r.we    = 1'b1;
          end else begin
            r.pixel = dst & dmask;
          end
        end else if (do_blend) begin
          r.uns = 1'b1;
        end else begin
          r.pixel = w;
          r.we    = 1'b1;
        end
      end else if (cfg_dst == DST_FMT_16) begin
        r.pixel = {16'd0, to_rgb565(raw)};
        r.we    = 1'b1;
      end else begin
        r.uns = 1'b1;
      end
    end else begin
      alpha_zero = (src[31:24] == 8'd0);
      if (cfg_dst == DST_FMT_16) begin
        if (do_blend) begin
          if (alpha_zero) begin
            r.pixel = dst & dmask;
          end else begin
            j = dst[15:0];
            if (cfg_swap) j = byte_swap16(j);
            db = {j[15:11], 3'b000};
            dg = {j[10:5], 2'b00};
            dr = {j[4:0], 3'b000};
            a  = src[31:24];
            r8 = 8'(mix_channel(src[23:16], dr, a));
            g8 = 8'(mix_channel(src[15:8], dg, a));
            b8 = 8'(mix_channel(src[7:0], db, a));
            j  = {b8[7:3], g8[7:2], r8[7:3]};
            r.pixel = {16'd0, cfg_swap ? byte_swap16(j) : j};
            r.we    = 1'b1;
          end
        end else if (do_test && alpha_zero) begin
          r.pixel = dst & dmask;
        end else begin
          r.pixel = {16'd0, to_rgb565(src)};
          r.we    = 1'b1;
        end
      end else if (cfg_dst == DST_FMT_32) begin
        if (do_test) begin
          if (alpha_zero) begin
            r.pixel = dst;
          end else begin
            r.pixel = src;
            r.we    = 1'b1;
          end
        end else if (do_blend) begin
          r.uns = 1'b1;
        end else begin
          r.pixel = src;
          r.we    = 1'b1;
        end
      end else begin
        r.uns = 1'b1;
      end
    end
    return r;
  endfunction

  // Driver: holds an offered item until it is taken, predicts at the transfer.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_axis_tready_o) begin
        if (cur_item.cmd == CMD_CONVERT) begin
          expected_writes.push_back(predict_blit(cur_item.src, cur_item.dst));
        end else begin
          palette_model[cur_item.slot] = cur_item.src;
        end
        accepted_total++;
      end
      if (!s_tvalid || s_axis_tready_o) begin
        if (blit_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_item = blit_queue.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {cur_item.dst, cur_item.slot, cur_item.src};
          s_tuser  <= cur_item.cmd;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic compare_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %h, actual %h", field, want, got);
      mismatches++;
    end
  endtask

  // Monitor and receiver back-pressure.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tready   <= 1'b0;
      stall_left <= 0;
    end else begin
      if (m_axis_tvalid_o && m_tready) begin
        if (expected_writes.size() == 0) begin
          $error("unexpected result: pixel_out %h, tuser %b", m_axis_tdata_o, m_axis_tuser_o);
          mismatches++;
        end else begin
          head_write = expected_writes.pop_front();
          compare_field("pixel_out", head_write.pixel, m_axis_tdata_o);
          compare_field("write_enable", {31'd0, head_write.we}, {31'd0, m_axis_tuser_o[0]});
          compare_field("unsupported", {31'd0, head_write.uns}, {31'd0, m_axis_tuser_o[1]});
        end
      end
      if (stall_served != stall_requests) begin
        stall_served <= stall_requests;
        stall_left   <= LONG_STALL;
        m_tready     <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        m_tready   <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_tvalid && s_axis_tready_o) || (m_axis_tvalid_o && m_tready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
  endtask

  task automatic configure(logic src, logic [1:0] dst, logic [1:0] blend,
                           logic [8:0] colors, logic swap);
    write_reg(CFG_SOURCE_FORMAT, {8'd0, src});
    write_reg(CFG_DEST_FORMAT, {7'd0, dst});
    write_reg(CFG_BLEND_FLAGS, {7'd0, blend});
    write_reg(CFG_PALETTE_COLORS, colors);
    write_reg(CFG_SWAP_BYTES, {8'd0, swap});
    @(posedge clk_i);
    cfg_we     <= 1'b0;
    cfg_src    = src;
    cfg_dst    = dst;
    cfg_blend  = blend;
    cfg_colors = colors;
    cfg_swap   = swap;
  endtask

  task automatic add_load(logic [7:0] slot, logic [31:0] word);
    blit_queue.push_back('{cmd: CMD_LOAD, src: word, slot: slot, dst: $urandom});
    slot_written[slot] = 1'b1;
    pushed_total++;
  endtask

  // Any palette entry below the color count must hold a loaded word first.
  task automatic add_convert(logic [31:0] src, logic [31:0] dst);
    if ({1'b0, src[7:0]} < cfg_colors && !slot_written[src[7:0]]) begin
      add_load(src[7:0], $urandom);
    end
    blit_queue.push_back('{cmd: CMD_CONVERT, src: src, slot: 8'($urandom), dst: dst});
    pushed_total++;
  endtask

  function automatic logic [31:0] random_source();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(5))
      0: v[31:24] = 8'h00;
      1: v[31:24] = 8'hFF;
      2: v[7:0]   = 8'h00;
      3: if (cfg_colors != 0) v[7:0] = 8'($urandom_range(int'(cfg_colors) - 1));
      default: ;
    endcase
    return v;
  endfunction

  task automatic add_random_items(int n);
    repeat (n) begin
      if ($urandom_range(4) == 0) begin
        add_load(8'($urandom), $urandom);
      end else begin
        add_convert(random_source(), $urandom);
      end
    end
  endtask

  // Loads give no result, so it waits for acceptance too, then settles.
  task automatic wait_idle();
    while (accepted_total != pushed_total || expected_writes.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [8:0] pick_colors();
    case ($urandom_range(4))
      0:       return 9'd0;
      1:       return 9'd256;
      2:       return 9'd1;
      3:       return 9'd255;
      default: return 9'($urandom_range(256));
    endcase
  endfunction

  initial begin
    int phase;
    phase         = 0;
    send_idle_pct = 10;
    recv_idle_pct = 79;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Index to ARGB with alpha test: inverted palette alpha and the grey ramp.
    configure(SRC_FMT_INDEX, DST_FMT_32, 2'b01, 9'd4, 1'b1);
    add_load(8'd0, 32'h0000_0000);
    add_load(8'd1, 32'hFFFF_FFFF);
    add_load(8'd2, 32'h8012_3456);
    add_load(8'd3, 32'h7F00_FF00);
    add_load(8'd255, 32'hA5A5_A5A5);
    add_convert(32'h0000_0000, 32'hFFFF_FFFF);
    add_convert(32'hFFFF_FF01, 32'h0000_0000);
    add_convert(32'h0000_0002, 32'hFFFF_FFFF);
    add_convert(32'h1234_5603, 32'h0000_0000);
    add_convert(32'h0000_0004, 32'hFFFF_FFFF);
    add_convert(32'h0000_00FF, 32'h0000_0000);
    wait_idle();

    // ARGB to RGB565 blend: alpha zero, full, half and minimal.
    configure(SRC_FMT_ARGB, DST_FMT_16, 2'b11, 9'd256, 1'b1);
    add_convert(32'h00FF_FFFF, 32'hFFFF_FFFF);
    add_convert(32'hFFFF_FFFF, 32'h0000_0000);
    add_convert(32'h8000_0000, 32'h0000_FFFF);
    add_convert(32'h01FF_00FF, 32'hABCD_1234);
    wait_idle();

    // Index to 8-bit with blend flag only: index zero leaves the pixel alone.
    configure(SRC_FMT_INDEX, DST_FMT_8, 2'b10, 9'd0, 1'b0);
    add_convert(32'hFFFF_FF00, 32'hFFFF_FFFF);
    add_convert(32'h0000_0007, 32'h0000_0000);
    wait_idle();

    for (int s = 0; s < 2; s++) begin
      for (int d = 0; d < 4; d++) begin
        for (int b = 0; b < 4; b++) begin
          for (int w = 0; w < 2; w++) begin
            if (phase == 21) begin
              send_idle_pct = 79;
              recv_idle_pct = 10;
            end else if (phase == 42) begin
              send_idle_pct = 0;
              recv_idle_pct = 0;
            end
            configure(s[0], d[1:0], b[1:0], pick_colors(), w[0]);
            add_random_items(6);
            wait_idle();
            phase++;
          end
        end
      end
    end

    // The receiver holds off while the sender keeps offering, so the block fills up.
    configure(SRC_FMT_ARGB, DST_FMT_16, 2'b10, 9'd256, 1'b0);
    stall_requests++;
    add_random_items(40);
    wait_idle();

    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
